@@ src/fdel_pkg.sv @@
// ----------------------------------------------------------------------------
// fdel_pkg
// shared widths, codes, types and helpers of the id queue with delete by id
// ----------------------------------------------------------------------------
package fdel_pkg;

    localparam int DEPTH     = 16;
    localparam int ID_BITS   = 16;
    localparam int MOVE_BITS = 8;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    localparam int MODE_BITS     = 2;
    localparam int CAR_ID_BITS   = 16;
    localparam int STATUS_BITS   = 3;
    localparam int OUT_ID_BITS   = 16;
    localparam int OUT_MOVE_BITS = 8;
    localparam int OCC_BITS      = 5;

    localparam int ENTRY_BITS = ID_BITS + MOVE_BITS;

    localparam logic [MODE_BITS-1:0] MODE_ENQ  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_DEL  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LIST = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_ENQUEUED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_LISTED    = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd5;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [MOVE_BITS-1:0] moves;
    } entry_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]   status;
        logic [OUT_ID_BITS-1:0]   entry_id;
        logic [OUT_MOVE_BITS-1:0] entry_moves;
        logic [OCC_BITS-1:0]      occupancy;
        logic                     last;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t res;
    } push_t;

    function automatic logic [MOVE_BITS-1:0] sat_inc(input logic [MOVE_BITS-1:0] m);
        logic [MOVE_BITS-1:0] r;
        if (&m)
        begin
            r = m;
        end
        else
        begin
            r = m + 1'b1;
        end
        return r;
    endfunction

endpackage

@@ src/fdel_if.sv @@
// ----------------------------------------------------------------------------
// fdel_if
// valid/ready channels of the id queue: command in, result out
// ----------------------------------------------------------------------------
interface fdel_in_if;
    logic                               valid;
    logic                               ready;
    logic [fdel_pkg::MODE_BITS-1:0]     mode;
    logic [fdel_pkg::CAR_ID_BITS-1:0]   car_id;

    modport source (output valid, output mode, output car_id, input ready);
    modport sink   (input valid, input mode, input car_id, output ready);
endinterface

interface fdel_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [fdel_pkg::STATUS_BITS-1:0]     status;
    logic [fdel_pkg::OUT_ID_BITS-1:0]     entry_id;
    logic [fdel_pkg::OUT_MOVE_BITS-1:0]   entry_moves;
    logic [fdel_pkg::OCC_BITS-1:0]        occupancy;
    logic                                 last;

    modport source (output valid, output status, output entry_id, output entry_moves,
                    output occupancy, output last, input ready);
    modport sink   (input valid, input status, input entry_id, input entry_moves,
                    input occupancy, input last, output ready);
endinterface

@@ src/fdel_ram.sv @@
// ----------------------------------------------------------------------------
// fdel_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module fdel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/fdel_obuf.sv @@
// ----------------------------------------------------------------------------
// fdel_obuf
// output register between the sequencer and the result channel
// ----------------------------------------------------------------------------
module fdel_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  fdel_pkg::push_t     pu,
    output logic                free,
    fdel_out_if.source          rsp
);

    logic              valid_reg;
    logic              valid_next;
    fdel_pkg::result_t res_reg;

    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (pu.push)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pu.push)
        begin
            res_reg <= pu.res;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.status      = res_reg.status;
    assign rsp.entry_id    = res_reg.entry_id;
    assign rsp.entry_moves = res_reg.entry_moves;
    assign rsp.occupancy   = res_reg.occupancy;
    assign rsp.last        = res_reg.last;

endmodule

@@ src/fdel_engine.sv @@
// ----------------------------------------------------------------------------
// fdel_engine
// command sequencer: enqueue, compacting delete walk and list walk over the ram
// ----------------------------------------------------------------------------
module fdel_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    fdel_in_if.sink                             cmd,
    input  logic                                obuf_free,
    output fdel_pkg::push_t                     pu,
    output logic                                ram_we,
    output logic [fdel_pkg::ADDR_BITS-1:0]      ram_waddr,
    output logic [fdel_pkg::ENTRY_BITS-1:0]     ram_wdata,
    output logic                                ram_re,
    output logic [fdel_pkg::ADDR_BITS-1:0]      ram_raddr,
    input  logic [fdel_pkg::ENTRY_BITS-1:0]     ram_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RESP = 2'd1;
    localparam logic [1:0] S_DEL  = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [fdel_pkg::CNT_BITS-1:0]      fill_reg, fill_next;
    logic [fdel_pkg::CNT_BITS-1:0]      rd_idx_reg, rd_idx_next;
    logic [fdel_pkg::CNT_BITS-1:0]      wr_idx_reg, wr_idx_next;
    logic [fdel_pkg::ID_BITS-1:0]       key_reg, key_next;
    logic                               hit_reg, hit_next;
    logic [fdel_pkg::STATUS_BITS-1:0]   status_reg, status_next;

    fdel_pkg::entry_t                   rd_entry;
    fdel_pkg::entry_t                   wr_entry;
    logic                               match;

    assign rd_entry  = fdel_pkg::entry_t'(ram_rdata);
    assign ram_wdata = fdel_pkg::ENTRY_BITS'(wr_entry);
    assign match     = (rd_entry.id == key_reg);
    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        key_next    = key_reg;
        hit_next    = hit_reg;
        status_next = status_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg[fdel_pkg::ADDR_BITS-1:0];
        wr_entry  = '0;
        ram_re    = 1'b0;
        ram_raddr = rd_idx_reg[fdel_pkg::ADDR_BITS-1:0];

        pu                 = '0;
        pu.res.occupancy   = fdel_pkg::OCC_BITS'(fill_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    key_next    = cmd.car_id[fdel_pkg::ID_BITS-1:0];
                    hit_next    = 1'b0;
                    wr_idx_next = '0;
                    rd_idx_next = fdel_pkg::CNT_BITS'(1);
                    case (cmd.mode)
                        fdel_pkg::MODE_ENQ:
                        begin
                            state_next = S_RESP;
                            if (fill_reg < fdel_pkg::CNT_BITS'(fdel_pkg::DEPTH))
                            begin
                                ram_we         = 1'b1;
                                ram_waddr      = fill_reg[fdel_pkg::ADDR_BITS-1:0];
                                wr_entry.id    = cmd.car_id[fdel_pkg::ID_BITS-1:0];
                                wr_entry.moves = '0;
                                fill_next      = fill_reg + 1'b1;
                                status_next    = fdel_pkg::ST_ENQUEUED;
                            end
                            else
                            begin
                                status_next = fdel_pkg::ST_FULL;
                            end
                        end
                        fdel_pkg::MODE_DEL:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = fdel_pkg::ST_NOT_FOUND;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = S_DEL;
                            end
                        end
                        fdel_pkg::MODE_LIST:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = fdel_pkg::ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (obuf_free)
                begin
                    pu.push       = 1'b1;
                    pu.res.status = status_reg;
                    pu.res.last   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DEL:
            begin
                // read data belongs to entry rd_idx-1, write slot trails the read
                if (match)
                begin
                    hit_next = 1'b1;
                end
                else
                begin
                    ram_we         = 1'b1;
                    wr_entry.id    = rd_entry.id;
                    wr_entry.moves = fdel_pkg::sat_inc(rd_entry.moves);
                    wr_idx_next    = wr_idx_reg + 1'b1;
                end
                if (rd_idx_reg < fill_reg)
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else
                begin
                    fill_next   = match ? wr_idx_reg : wr_idx_reg + 1'b1;
                    status_next = (hit_reg || match) ? fdel_pkg::ST_REMOVED
                                                     : fdel_pkg::ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
            end
            S_LIST:
            begin
                if (obuf_free)
                begin
                    pu.push            = 1'b1;
                    pu.res.status      = fdel_pkg::ST_LISTED;
                    pu.res.entry_id    = fdel_pkg::OUT_ID_BITS'(rd_entry.id);
                    pu.res.entry_moves = fdel_pkg::OUT_MOVE_BITS'(rd_entry.moves);
                    pu.res.last        = (rd_idx_reg == fill_reg);
                    if (rd_idx_reg == fill_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        key_reg    <= key_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
    end

endmodule

@@ src/fifo_with_delete_by_id.sv @@
// ----------------------------------------------------------------------------
// fifo_with_delete_by_id
// ordered id queue with move counters, delete by id and listing
// ----------------------------------------------------------------------------
// cmd channel: one transaction per command (mode, car_id); rsp channel: one
// transaction per result, last marks the final result of a command.
// commands are taken one at a time; cmd.ready is high only while the
// sequencer is idle, and results leave through a one-entry output register.
// with n entries stored:
//   enqueue: the entry is written to the ram on acceptance, then one result
//   delete: one ram read per entry, a write-back per non-matching entry
//   list: one entry per cycle from the ram while rsp does not stall
// the single ram read port makes each walk read its entries one by one.
// mode 3 is accepted and dropped with no result.
// reset empties the queue (fill count to zero); ram contents are not cleared.
// a stall on rsp holds the output register and pauses the sequencer except in a delete walk;
// the next command is taken while the last result still waits in the register.
// ----------------------------------------------------------------------------
module fifo_with_delete_by_id (
    input  logic        clk,
    input  logic        rst_n,
    fdel_in_if.sink     cmd,
    fdel_out_if.source  rsp
);

    fdel_pkg::push_t                    pu;
    logic                               obuf_free;
    logic                               ram_we;
    logic [fdel_pkg::ADDR_BITS-1:0]     ram_waddr;
    logic [fdel_pkg::ENTRY_BITS-1:0]    ram_wdata;
    logic                               ram_re;
    logic [fdel_pkg::ADDR_BITS-1:0]     ram_raddr;
    logic [fdel_pkg::ENTRY_BITS-1:0]    ram_rdata;

    fdel_ram #(
        .WIDTH (fdel_pkg::ENTRY_BITS),
        .DEPTH (fdel_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fdel_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .obuf_free (obuf_free),
        .pu        (pu),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    fdel_obuf u_obuf (
        .clk   (clk),
        .rst_n (rst_n),
        .pu    (pu),
        .free  (obuf_free),
        .rsp   (rsp)
    );

    // occupancy never exceeds the queue depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.occupancy <= fdel_pkg::OCC_BITS'(fdel_pkg::DEPTH))
        else $error("occupancy above depth");

    // only listed entries can be followed by more results
    a_not_last_listed: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> rsp.status == fdel_pkg::ST_LISTED)
        else $error("non-final result that is not a listed entry");

    // entry fields are zero outside listed entries
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != fdel_pkg::ST_LISTED)
            |-> (rsp.entry_id == '0 && rsp.entry_moves == '0))
        else $error("entry fields set on a non-listing result");

    // no new command is taken in the middle of a listing
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (pu.push && !pu.res.last) |-> !cmd.ready)
        else $error("command accepted in the middle of a listing");

endmodule
